@@ hw/rtl/rte_pkg.sv @@
`timescale 1ns / 1ps
package rte_pkg;

    localparam int MAX_SAMPLES  = 128;
    localparam int SAMPLE_WIDTH = 32;
    localparam int AW           = $clog2(MAX_SAMPLES);
    localparam int CW           = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW         = SAMPLE_WIDTH + CW;
    localparam int DCW          = $clog2(SUMW + 1);
    localparam int PW           = 4;
    localparam int PRODW        = CW + PW;
    localparam int CONFW        = 7;

    localparam logic [PW-1:0] LAST_PASS  = PW'(9);
    localparam logic [PW-1:0] PASS_NINE  = PW'(9);
    localparam logic [6:0]    CONF_SCALE = 7'd100;

    // x/10 == (x*52429)>>19 and x/3 == (x*43691)>>17 for all counts used here
    localparam int RECIP_W          = 16;
    localparam logic [RECIP_W-1:0] RECIP10 = 16'd52429;
    localparam int RECIP10_SHIFT    = 19;
    localparam logic [RECIP_W-1:0] RECIP3  = 16'd43691;
    localparam int RECIP3_SHIFT     = 17;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PREP,
        S_SORT_FIRST,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_TAIL,
        S_PASS_A,
        S_PASS_B,
        S_PASS_C,
        S_SUM,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_CONF_GO,
        S_CONF_WAIT,
        S_DECIDE,
        S_OUT
    } t_state;

endpackage

@@ hw/rtl/rte_ram.sv @@
`timescale 1ns / 1ps
module rte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rte_div.sv @@
`timescale 1ns / 1ps
module rte_div
    import rte_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SUMW-1:0] i_dividend,
    input  logic [CW-1:0]   i_divisor,
    output logic            o_done,
    output logic [SUMW-1:0] o_quotient
);

    logic [SUMW-1:0] r_q;
    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_div;
    logic [DCW-1:0]  r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [CW:0]     trial;
    logic [CW:0]     diff;
    logic            ge;

    always_comb begin
        trial = {r_rem, r_q[SUMW-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one quotient bit per cycle, restoring
                r_q   <= {r_q[SUMW-2:0], ge};
                r_rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCW'(SUMW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ hw/rtl/robust_timing_estimator_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Ports
// -------   ---------------------  -----------------------------------
// sample    i_start & !o_busy      i_sample_value, i_last_sample
// result    o_valid (one cycle)    o_estimate, o_confidence
//
// Samples may arrive back to back while not busy; each is written into the sample memory until it is full.
// After the sample marked last the block is busy: a bubble sort over the
// kept M samples (one memory read and write per compare), then up to ten
// window passes, each paced by the memory read port and the bit-serial
// divider.
// Synchronous reset clears the control state; memory contents need none.
// The result strobe lasts one cycle and the receiver cannot stall it.
module robust_timing_estimator_top
    import rte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [31:0]       i_sample_value,
    input  logic              i_last_sample,
    output logic              o_valid,
    output logic [31:0]       o_estimate,
    output logic [CONFW-1:0]  o_confidence
);

    t_state r_state, n_state;

    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_n, n_n;
    logic [AW-1:0]           r_base, n_base;
    logic [CW-1:0]           r_m, n_m;
    logic [CW-1:0]           r_mid, n_mid;
    logic [AW-1:0]           r_end, n_end;
    logic [AW-1:0]           r_sidx, n_sidx;
    logic [SAMPLE_WIDTH-1:0] r_hold, n_hold;
    logic [PW-1:0]           r_pass, n_pass;
    logic [PRODW-1:0]        r_pa, n_pa;
    logic [PRODW-1:0]        r_pb, n_pb;
    logic [CW-1:0]           r_from, n_from;
    logic [CW-1:0]           r_to, n_to;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_wcnt, n_wcnt;
    logic [SUMW-1:0]         r_sum, n_sum;
    logic [SAMPLE_WIDTH-1:0] r_first, n_first;
    logic [SAMPLE_WIDTH-1:0] r_last, n_last;
    logic                    r_got_first, n_got_first;
    logic [SAMPLE_WIDTH-1:0] r_mean, n_mean;
    logic [CONFW-1:0]        r_conf, n_conf;
    logic [SAMPLE_WIDTH-1:0] r_best, n_best;
    logic [CONFW-1:0]        r_best_conf, n_best_conf;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [SAMPLE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;

    logic                    div_start;
    logic [SUMW-1:0]         div_dividend;
    logic [CW-1:0]           div_divisor;
    logic                    div_done;
    logic [SUMW-1:0]         div_quotient;

    logic                    accept;
    logic [CW+RECIP_W-1:0]   third_prod;
    logic [PRODW+RECIP_W-1:0] from_prod;
    logic [PRODW+RECIP_W-1:0] to_prod;
    logic [SAMPLE_WIDTH-1:0] delta;

    rte_ram #(
        .WIDTH(SAMPLE_WIDTH),
        .DEPTH(MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign accept = i_start && (r_state == S_LOAD);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_base      = r_base;
        n_m         = r_m;
        n_mid       = r_mid;
        n_end       = r_end;
        n_sidx      = r_sidx;
        n_hold      = r_hold;
        n_pass      = r_pass;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_from      = r_from;
        n_to        = r_to;
        n_idx       = r_idx;
        n_wcnt      = r_wcnt;
        n_sum       = r_sum;
        n_first     = r_first;
        n_last      = r_last;
        n_got_first = r_got_first;
        n_mean      = r_mean;
        n_conf      = r_conf;
        n_best      = r_best;
        n_best_conf = r_best_conf;

        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        third_prod = (CW+RECIP_W)'(r_n) * (CW+RECIP_W)'(RECIP3);
        from_prod  = (PRODW+RECIP_W)'(r_pa) * (PRODW+RECIP_W)'(RECIP10);
        to_prod    = (PRODW+RECIP_W)'(r_pb) * (PRODW+RECIP_W)'(RECIP10);
        delta      = (r_last - r_first) >> 1;

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    // drop samples once the store is full
                    if (r_count < CW'(MAX_SAMPLES)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = i_sample_value[SAMPLE_WIDTH-1:0];
                        n_count   = r_count + 1'b1;
                    end
                    if (i_last_sample) begin
                        n_n     = n_count;
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_base  = AW'(third_prod >> RECIP3_SHIFT);
                n_m     = r_n - CW'(third_prod >> RECIP3_SHIFT);
                n_mid   = n_m >> 1;
                n_end   = AW'(r_n - 1'b1);
                n_pass  = '0;
                n_best      = '0;
                n_best_conf = '0;
                n_state = (n_m > CW'(1)) ? S_SORT_FIRST : S_PASS_A;
            end
            S_SORT_FIRST: begin
                ram_raddr = r_base;
                n_state   = S_SORT_LOAD;
            end
            S_SORT_LOAD: begin
                n_hold    = ram_rdata;
                ram_raddr = r_base + 1'b1;
                n_sidx    = r_base + 1'b1;
                n_state   = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                // bubble the larger value upward, write back the smaller
                ram_we    = 1'b1;
                ram_waddr = r_sidx - 1'b1;
                if (r_hold > ram_rdata) begin
                    ram_wdata = ram_rdata;
                end else begin
                    ram_wdata = r_hold;
                    n_hold    = ram_rdata;
                end
                if (r_sidx == r_end) begin
                    n_state = S_SORT_TAIL;
                end else begin
                    ram_raddr = r_sidx + 1'b1;
                    n_sidx    = r_sidx + 1'b1;
                end
            end
            S_SORT_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = r_end;
                ram_wdata = r_hold;
                n_end     = r_end - 1'b1;
                n_state   = (n_end == r_base) ? S_PASS_A : S_SORT_FIRST;
            end
            S_PASS_A: begin
                n_pa    = PRODW'(r_mid) * PRODW'(PASS_NINE - r_pass);
                n_pb    = PRODW'(r_m - r_mid) * PRODW'(r_pass + 1'b1);
                n_state = S_PASS_B;
            end
            S_PASS_B: begin
                n_from  = CW'(from_prod >> RECIP10_SHIFT);
                n_to    = r_mid + CW'(to_prod >> RECIP10_SHIFT);
                n_state = S_PASS_C;
            end
            S_PASS_C: begin
                n_sum       = '0;
                n_got_first = 1'b0;
                if (r_to > r_from) begin
                    n_wcnt    = r_to - r_from;
                    ram_raddr = r_base + AW'(r_from);
                    n_idx     = r_from + 1'b1;
                    n_state   = S_SUM;
                end else begin
                    n_mean  = '0;
                    n_conf  = '0;
                    n_first = '0;
                    n_last  = '0;
                    n_state = S_DECIDE;
                end
            end
            S_SUM: begin
                n_sum = r_sum + SUMW'(ram_rdata);
                if (!r_got_first) begin
                    n_first     = ram_rdata;
                    n_got_first = 1'b1;
                end
                if (r_idx == r_to) begin
                    n_last  = ram_rdata;
                    n_state = S_MEAN_GO;
                end else begin
                    ram_raddr = r_base + AW'(r_idx);
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = r_sum;
                div_divisor  = r_wcnt;
                n_state      = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (div_done) begin
                    n_mean  = div_quotient[SAMPLE_WIDTH-1:0];
                    n_state = S_CONF_GO;
                end
            end
            S_CONF_GO: begin
                div_start    = 1'b1;
                div_dividend = SUMW'(r_wcnt) * SUMW'(CONF_SCALE);
                div_divisor  = r_m;
                n_state      = S_CONF_WAIT;
            end
            S_CONF_WAIT: begin
                if (div_done) begin
                    n_conf  = div_quotient[CONFW-1:0];
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // stop once the window spread (rounded down to even) exceeds the mean, from the second pass on
                if ((r_pass != '0) && ({delta, 1'b0} > {1'b0, r_mean})) begin
                    n_state = S_OUT;
                end else begin
                    n_best      = r_mean;
                    n_best_conf = r_conf;
                    if (r_pass == LAST_PASS) begin
                        n_state = S_OUT;
                    end else begin
                        n_pass  = r_pass + 1'b1;
                        n_state = S_PASS_A;
                    end
                end
            end
            S_OUT: begin
                n_count = '0;
                n_state = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_pass      <= '0;
            r_best      <= '0;
            r_best_conf <= '0;
            r_sum       <= '0;
            r_got_first <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pass      <= n_pass;
            r_best      <= n_best;
            r_best_conf <= n_best_conf;
            r_sum       <= n_sum;
            r_got_first <= n_got_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_base  <= n_base;
        r_m     <= n_m;
        r_mid   <= n_mid;
        r_end   <= n_end;
        r_sidx  <= n_sidx;
        r_hold  <= n_hold;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_from  <= n_from;
        r_to    <= n_to;
        r_idx   <= n_idx;
        r_wcnt  <= n_wcnt;
        r_first <= n_first;
        r_last  <= n_last;
        r_mean  <= n_mean;
        r_conf  <= n_conf;
    end

    assign o_busy       = (r_state != S_LOAD);
    assign o_valid      = (r_state == S_OUT);
    assign o_estimate   = 32'(r_best);
    assign o_confidence = r_best_conf;

endmodule
